// File: rtl/dtbl_pkg.sv
// Shared types and constants of the dual token bucket limiter.
`default_nettype none
package dtbl_pkg;
  localparam int unsigned TableDepth = 64;
  localparam int unsigned KeyBits    = 64;
  localparam int unsigned TimeBits   = 48;
  localparam int unsigned TokBits    = 26;
  localparam int unsigned AgeBits    = 64;
  localparam int unsigned RateBits   = 16;
  localparam int unsigned LimBits    = 7;
  localparam int unsigned CntOutBits = 7;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned CfgIdxBits = 3;

  localparam logic [TokBits-1:0]  UnitsPerToken    = 26'd1000;
  localparam logic [RateBits-1:0] RstCallerRate    = 16'd10;
  localparam logic [RateBits-1:0] RstCallerBurst   = 16'd20;
  localparam logic [RateBits-1:0] RstIdentityRate  = 16'd5;
  localparam logic [RateBits-1:0] RstIdentityBurst = 16'd10;
  localparam logic [LimBits-1:0]  RstLimit         = 7'd64;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_CALLER_RATE    = 3'd0,
    CFG_CALLER_BURST   = 3'd1,
    CFG_IDENTITY_RATE  = 3'd2,
    CFG_IDENTITY_BURST = 3'd3,
    CFG_CALLER_LIMIT   = 3'd4,
    CFG_IDENTITY_LIMIT = 3'd5
  } cfg_idx_e;

  typedef enum logic [StatusBits-1:0] {
    ST_OK   = 2'd0,
    ST_BUSY = 2'd1,
    ST_BACK = 2'd2
  } status_e;

  typedef enum logic {
    TBL_CALLER   = 1'b0,
    TBL_IDENTITY = 1'b1
  } tbl_e;

  typedef enum logic {
    ITEM_ACQUIRE = 1'b0,
    ITEM_SUCCESS = 1'b1
  } item_cmd_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_SCAN_START,
    DP_SCAN,
    DP_RESOLVE,
    DP_READ,
    DP_DIFF,
    DP_MUL,
    DP_SAT,
    DP_FINAL,
    DP_FORGET,
    DP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    tbl_e   tbl;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic back;
    logic out_stall;
  } dp_stat_t;
endpackage
`default_nettype wire

// File: rtl/dtbl_if.sv
// Item channel interfaces of the limiter: request and response.
`default_nettype none
interface dtbl_req_if #(
  parameter int unsigned KEY_BITS  = dtbl_pkg::KeyBits,
  parameter int unsigned TIME_BITS = dtbl_pkg::TimeBits
) ();
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [KEY_BITS-1:0]  caller_key;
  logic [KEY_BITS-1:0]  identity_key;
  logic [TIME_BITS-1:0] now_ms;

  modport source (output valid, cmd, caller_key, identity_key, now_ms, input ready);
  modport sink (input valid, cmd, caller_key, identity_key, now_ms, output ready);
endinterface

interface dtbl_rsp_if ();
  logic                                valid;
  logic                                ready;
  logic [dtbl_pkg::StatusBits-1:0]     status;
  logic [dtbl_pkg::CntOutBits-1:0]     caller_count;
  logic [dtbl_pkg::CntOutBits-1:0]     identity_count;

  modport source (output valid, status, caller_count, identity_count, input ready);
  modport sink (input valid, status, caller_count, identity_count, output ready);
endinterface
`default_nettype wire

// File: rtl/dual_token_bucket_lru_limiter_unit.sv
// Top level of the dual token bucket limiter with least recently used tables.
`default_nettype none
// The unit keeps two tables of token buckets, one keyed by a hashed caller
// key and one by a hashed identity key, each of TABLE_DEPTH entries held in
// RAMs with a registered read, with valid bits in flip-flops. An acquire item searches
// the caller table and then the identity table in a linear scan that reads
// one entry per cycle, inserts a missing key (evicting the least recently
// used entry when the table is at its limit), refills both buckets through
// a subtract, multiply and saturate sequence, and grants when both hold a
// whole token. A success item scans the identity table and drops the entry.
// An acquire whose time lies before a stored bucket stamp ends early with a
// back status and no grant. One item is worked on at a time; the result
// waits in an output register so the next item is taken while an earlier
// result is still pending. Every item yields exactly one result.
// Configuration is written through the plain write port; the user must
// write it only while the unit is idle, which the unit itself does not
// enforce.
module dual_token_bucket_lru_limiter_unit #(
  parameter int unsigned TABLE_DEPTH = dtbl_pkg::TableDepth,
  parameter int unsigned KEY_BITS    = dtbl_pkg::KeyBits,
  parameter int unsigned TIME_BITS   = dtbl_pkg::TimeBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dtbl_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [dtbl_pkg::RateBits-1:0]   cfg_data_i,
  dtbl_req_if.sink                        req_if,
  dtbl_rsp_if.source                      rsp_if
);
  import dtbl_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     in_ready;
  logic     in_acc;

  // An item is taken when the sequencer is idle and the source offers one.
  assign req_if.ready = in_ready;
  assign in_acc       = req_if.valid && in_ready;

  dtbl_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_acc_i   (in_acc),
    .in_cmd_i   (req_if.cmd),
    .in_ready_o (in_ready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // The datapath owns the tables, the refill arithmetic and the result register.
  dtbl_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_acc_i       (in_acc),
    .caller_key_i   (req_if.caller_key),
    .identity_key_i (req_if.identity_key),
    .now_ms_i       (req_if.now_ms),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .out_ready_i    (rsp_if.ready),
    .out_valid_o    (rsp_if.valid),
    .out_status_o   (rsp_if.status),
    .out_ccount_o   (rsp_if.caller_count),
    .out_icount_o   (rsp_if.identity_count)
  );
endmodule
`default_nettype wire

// File: rtl/dtbl_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none
module dtbl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// File: rtl/dtbl_dp.sv
// Datapath of the limiter: tables, scan trackers, refill arithmetic, result register.
`default_nettype none
module dtbl_dp #(
  parameter int unsigned TABLE_DEPTH = dtbl_pkg::TableDepth,
  parameter int unsigned KEY_BITS    = dtbl_pkg::KeyBits,
  parameter int unsigned TIME_BITS   = dtbl_pkg::TimeBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dtbl_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [dtbl_pkg::RateBits-1:0]     cfg_data_i,
  input  logic                              in_acc_i,
  input  logic [KEY_BITS-1:0]               caller_key_i,
  input  logic [KEY_BITS-1:0]               identity_key_i,
  input  logic [TIME_BITS-1:0]              now_ms_i,
  input  dtbl_pkg::dp_cmd_t                 cmd_i,
  output dtbl_pkg::dp_stat_t                stat_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [dtbl_pkg::StatusBits-1:0]   out_status_o,
  output logic [dtbl_pkg::CntOutBits-1:0]   out_ccount_o,
  output logic [dtbl_pkg::CntOutBits-1:0]   out_icount_o
);
  import dtbl_pkg::*;

  localparam int unsigned IdxBits  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntBits  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CmpBits  = (CntBits > LimBits) ? CntBits : LimBits;
  localparam int unsigned ProdBits = TIME_BITS + RateBits;
  localparam logic [IdxBits-1:0] LastIdx  = IdxBits'(TABLE_DEPTH - 1);
  localparam logic [CmpBits-1:0] DepthCmp = CmpBits'(TABLE_DEPTH);

  function automatic logic [AgeBits-1:0] next_seq(input logic [AgeBits-1:0] x);
    logic [AgeBits-1:0] r;
    r = (x == '1) ? AgeBits'(1) : x + AgeBits'(1);
    return r;
  endfunction

  // Configuration
  logic [RateBits-1:0] rate_q [2];
  logic [RateBits-1:0] burst_q [2];
  logic [LimBits-1:0]  limit_q [2];

  // Item
  logic [KEY_BITS-1:0]  key_q [2];
  logic [TIME_BITS-1:0] now_q;

  // Scan trackers
  logic [IdxBits-1:0]  idx_q, pidx_q, hit_idx_q, vic_idx_q, free_idx_q;
  logic                pend_q, hit_q, vic_q, free_q;
  logic [AgeBits-1:0]  vic_age_q;

  // Table state
  logic [TABLE_DEPTH-1:0] val_q [2];
  logic [CntBits-1:0]     cnt_q [2];
  logic [IdxBits-1:0]     slot_q [2];
  logic [AgeBits-1:0]     seq_q;

  // Refill
  logic [TokBits-1:0]   cur_q;
  logic [TokBits-1:0]   tok_q [2];
  logic [TIME_BITS-1:0] diff_q;
  logic                 lt_q;
  logic [ProdBits-1:0]  prod_q;
  status_e              res_q;

  // Result register
  logic                  out_valid_q;
  status_e               out_status_q;
  logic [CntOutBits-1:0] out_ccount_q, out_icount_q;

  // RAM read data
  logic [KEY_BITS-1:0]  rkey [2];
  logic [TokBits-1:0]   rtok [2];
  logic [TIME_BITS-1:0] rstamp [2];
  logic [AgeBits-1:0]   rage [2];

  logic                   sel;
  logic                   val_sel;
  logic [CmpBits-1:0]     cnt_ext, lim_ext, eff;
  logic                   need_evict;
  logic [IdxBits-1:0]     ins_slot;
  logic [TABLE_DEPTH-1:0] val_ins;
  logic [TokBits-1:0]     top_units, room, sat_val;
  logic [AgeBits-1:0]     seq1, seq2;
  logic                   grant;
  logic                   out_load;

  always_comb begin
    sel        = cmd_i.tbl;
    val_sel    = val_q[sel][pidx_q];
    cnt_ext    = CmpBits'(cnt_q[sel]);
    lim_ext    = CmpBits'(limit_q[sel]);
    eff        = (lim_ext < DepthCmp) ? lim_ext : DepthCmp;
    // Only a table that holds entries can have a victim.
    need_evict = (cnt_ext >= eff) && vic_q;
    ins_slot   = (need_evict && !(free_q && (free_idx_q < vic_idx_q))) ? vic_idx_q : free_idx_q;
    // Valid bits after an insertion: the victim drops out and the new slot comes in.
    val_ins    = val_q[sel];
    if (need_evict) begin
      val_ins[vic_idx_q] = 1'b0;
    end
    val_ins[ins_slot] = 1'b1;
    top_units  = TokBits'(burst_q[sel]) * UnitsPerToken;
    room       = top_units - cur_q;
    if ((cur_q >= top_units) || (prod_q >= ProdBits'(room))) begin
      sat_val = top_units;
    end else begin
      sat_val = cur_q + prod_q[TokBits-1:0];
    end
    seq1     = next_seq(seq_q);
    seq2     = next_seq(seq1);
    grant    = (tok_q[TBL_CALLER] >= UnitsPerToken) && (tok_q[TBL_IDENTITY] >= UnitsPerToken);
    out_load = (cmd_i.op == DP_OUT) && (!out_valid_q || out_ready_i);
  end

  for (genvar t = 0; t < 2; t++) begin : g_tbl
    logic                 is_t, res_ins, sat_t, fin;
    logic                 key_we, tok_we, stamp_we, age_we;
    logic [IdxBits-1:0]   waddr, raddr;
    logic [TokBits-1:0]   tok_wd;
    logic [AgeBits-1:0]   age_wd;

    always_comb begin
      is_t     = (cmd_i.tbl == tbl_e'(1'(t)));
      res_ins  = (cmd_i.op == DP_RESOLVE) && is_t && !hit_q;
      sat_t    = (cmd_i.op == DP_SAT) && is_t;
      fin      = (cmd_i.op == DP_FINAL);
      key_we   = res_ins;
      tok_we   = res_ins || sat_t || (fin && grant);
      stamp_we = res_ins || sat_t;
      age_we   = res_ins || fin;
      waddr    = res_ins ? ins_slot : slot_q[t];
      raddr    = (cmd_i.op == DP_SCAN) ? idx_q : slot_q[t];
      if (res_ins) begin
        tok_wd = top_units;
      end else if (sat_t) begin
        tok_wd = sat_val;
      end else begin
        tok_wd = tok_q[t] - UnitsPerToken;
      end
      // The caller entry takes its age before the identity entry.
      if (res_ins || (t == 0)) begin
        age_wd = seq1;
      end else begin
        age_wd = seq2;
      end
    end

    dtbl_ram #(.WIDTH(KEY_BITS), .DEPTH(TABLE_DEPTH)) u_key (
      .clk_i, .we_i(key_we), .waddr_i(waddr), .wdata_i(key_q[t]),
      .raddr_i(raddr), .rdata_o(rkey[t])
    );
    dtbl_ram #(.WIDTH(TokBits), .DEPTH(TABLE_DEPTH)) u_tok (
      .clk_i, .we_i(tok_we), .waddr_i(waddr), .wdata_i(tok_wd),
      .raddr_i(raddr), .rdata_o(rtok[t])
    );
    dtbl_ram #(.WIDTH(TIME_BITS), .DEPTH(TABLE_DEPTH)) u_stamp (
      .clk_i, .we_i(stamp_we), .waddr_i(waddr), .wdata_i(now_q),
      .raddr_i(raddr), .rdata_o(rstamp[t])
    );
    dtbl_ram #(.WIDTH(AgeBits), .DEPTH(TABLE_DEPTH)) u_age (
      .clk_i, .we_i(age_we), .waddr_i(waddr), .wdata_i(age_wd),
      .raddr_i(raddr), .rdata_o(rage[t])
    );
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q[TBL_CALLER]    <= RstCallerRate;
      burst_q[TBL_CALLER]   <= RstCallerBurst;
      rate_q[TBL_IDENTITY]  <= RstIdentityRate;
      burst_q[TBL_IDENTITY] <= RstIdentityBurst;
      limit_q[TBL_CALLER]   <= RstLimit;
      limit_q[TBL_IDENTITY] <= RstLimit;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CALLER_RATE:    rate_q[TBL_CALLER]    <= cfg_data_i;
        CFG_CALLER_BURST:   burst_q[TBL_CALLER]   <= cfg_data_i;
        CFG_IDENTITY_RATE:  rate_q[TBL_IDENTITY]  <= cfg_data_i;
        CFG_IDENTITY_BURST: burst_q[TBL_IDENTITY] <= cfg_data_i;
        CFG_CALLER_LIMIT:   limit_q[TBL_CALLER]   <= cfg_data_i[LimBits-1:0];
        CFG_IDENTITY_LIMIT: limit_q[TBL_IDENTITY] <= cfg_data_i[LimBits-1:0];
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc_i) begin
      key_q[TBL_CALLER]   <= caller_key_i;
      key_q[TBL_IDENTITY] <= identity_key_i;
      now_q              <= now_ms_i;
    end
    case (cmd_i.op)
      DP_SCAN: begin
        if (pend_q) begin
          if (val_sel && (rkey[sel] == key_q[sel])) begin
            hit_idx_q <= pidx_q;
          end
          if (val_sel && (!vic_q || (rage[sel] < vic_age_q))) begin
            vic_idx_q <= pidx_q;
            vic_age_q <= rage[sel];
          end
          if (!val_sel && !free_q) begin
            free_idx_q <= pidx_q;
          end
        end
      end
      DP_RESOLVE: slot_q[sel] <= hit_q ? hit_idx_q : ins_slot;
      DP_DIFF: begin
        diff_q <= now_q - rstamp[sel];
        cur_q  <= rtok[sel];
      end
      DP_MUL:  prod_q <= diff_q * rate_q[sel];
      DP_SAT:  tok_q[sel] <= sat_val;
      default: ;
    endcase
    if (out_load) begin
      out_status_q <= res_q;
      out_ccount_q <= CntOutBits'(cnt_q[TBL_CALLER]);
      out_icount_q <= CntOutBits'(cnt_q[TBL_IDENTITY]);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      pidx_q      <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      vic_q       <= 1'b0;
      free_q      <= 1'b0;
      val_q[0]    <= '0;
      val_q[1]    <= '0;
      cnt_q[0]    <= '0;
      cnt_q[1]    <= '0;
      seq_q       <= '0;
      lt_q        <= 1'b0;
      res_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc_i) begin
        res_q <= ST_OK;
        lt_q  <= 1'b0;
      end
      case (cmd_i.op)
        DP_SCAN_START: begin
          idx_q  <= '0;
          pend_q <= 1'b0;
          hit_q  <= 1'b0;
          vic_q  <= 1'b0;
          free_q <= 1'b0;
        end
        DP_SCAN: begin
          if (idx_q != LastIdx) begin
            idx_q <= idx_q + IdxBits'(1);
          end
          pend_q <= 1'b1;
          pidx_q <= idx_q;
          if (pend_q) begin
            if (val_sel && (rkey[sel] == key_q[sel])) begin
              hit_q <= 1'b1;
            end
            if (val_sel) begin
              vic_q <= 1'b1;
            end
            if (!val_sel) begin
              free_q <= 1'b1;
            end
          end
        end
        DP_RESOLVE: begin
          if (!hit_q) begin
            val_q[sel] <= val_ins;
            if (!need_evict) begin
              cnt_q[sel] <= cnt_q[sel] + CntBits'(1);
            end
            seq_q <= seq1;
          end
        end
        DP_DIFF: begin
          lt_q <= (now_q < rstamp[sel]);
          if (now_q < rstamp[sel]) begin
            res_q <= ST_BACK;
          end
        end
        DP_FINAL: begin
          seq_q <= seq2;
          res_q <= grant ? ST_OK : ST_BUSY;
        end
        DP_FORGET: begin
          if (hit_q) begin
            val_q[TBL_IDENTITY][hit_idx_q] <= 1'b0;
            cnt_q[TBL_IDENTITY]            <= cnt_q[TBL_IDENTITY] - CntBits'(1);
          end
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.scan_done = pend_q && (pidx_q == LastIdx);
  assign stat_o.back      = lt_q;
  assign stat_o.out_stall = out_valid_q && !out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_status_o     = out_status_q;
  assign out_ccount_o     = out_ccount_q;
  assign out_icount_o     = out_icount_q;
endmodule
`default_nettype wire

// File: rtl/dtbl_ctrl.sv
// Sequencer of the limiter: steps the datapath through scans, refills and the reply.
`default_nettype none
module dtbl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_acc_i,
  input  logic               in_cmd_i,
  output logic               in_ready_o,
  input  dtbl_pkg::dp_stat_t stat_i,
  output dtbl_pkg::dp_cmd_t  cmd_o
);
  import dtbl_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_C_SS, S_C_SC, S_C_RES, S_I_SS, S_I_SC, S_I_RES,
    S_C_RD, S_C_DF, S_C_MU, S_C_ST, S_I_RD, S_I_DF, S_I_MU, S_I_ST,
    S_FIN, S_FGT, S_OUT
  } state_e;

  state_e  state_q, state_d;
  logic    fgt_q;
  dp_cmd_t cmd_q;

  function automatic dp_cmd_t cmd_of(input state_e s);
    dp_cmd_t c;
    c.tbl = TBL_CALLER;
    c.op  = DP_NOP;
    unique case (s)
      S_C_SS:  c.op = DP_SCAN_START;
      S_C_SC:  c.op = DP_SCAN;
      S_C_RES: c.op = DP_RESOLVE;
      S_C_RD:  c.op = DP_READ;
      S_C_DF:  c.op = DP_DIFF;
      S_C_MU:  c.op = DP_MUL;
      S_C_ST:  c.op = DP_SAT;
      S_I_SS:  begin c.op = DP_SCAN_START; c.tbl = TBL_IDENTITY; end
      S_I_SC:  begin c.op = DP_SCAN;       c.tbl = TBL_IDENTITY; end
      S_I_RES: begin c.op = DP_RESOLVE;    c.tbl = TBL_IDENTITY; end
      S_I_RD:  begin c.op = DP_READ;       c.tbl = TBL_IDENTITY; end
      S_I_DF:  begin c.op = DP_DIFF;       c.tbl = TBL_IDENTITY; end
      S_I_MU:  begin c.op = DP_MUL;        c.tbl = TBL_IDENTITY; end
      S_I_ST:  begin c.op = DP_SAT;        c.tbl = TBL_IDENTITY; end
      S_FIN:   c.op = DP_FINAL;
      S_FGT:   begin c.op = DP_FORGET;     c.tbl = TBL_IDENTITY; end
      S_OUT:   c.op = DP_OUT;
      default: c.op = DP_NOP;
    endcase
    return c;
  endfunction

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc_i) begin
        state_d = (item_cmd_e'(in_cmd_i) == ITEM_SUCCESS) ? S_I_SS : S_C_SS;
      end
      S_C_SS:  state_d = S_C_SC;
      S_C_SC:  if (stat_i.scan_done) begin
        state_d = S_C_RES;
      end
      S_C_RES: state_d = S_I_SS;
      S_I_SS:  state_d = S_I_SC;
      S_I_SC:  if (stat_i.scan_done) begin
        state_d = fgt_q ? S_FGT : S_I_RES;
      end
      S_I_RES: state_d = S_C_RD;
      S_C_RD:  state_d = S_C_DF;
      S_C_DF:  state_d = S_C_MU;
      S_C_MU:  state_d = stat_i.back ? S_OUT : S_C_ST;
      S_C_ST:  state_d = S_I_RD;
      S_I_RD:  state_d = S_I_DF;
      S_I_DF:  state_d = S_I_MU;
      S_I_MU:  state_d = stat_i.back ? S_OUT : S_I_ST;
      S_I_ST:  state_d = S_FIN;
      S_FIN:   state_d = S_OUT;
      S_FGT:   state_d = S_OUT;
      S_OUT:   if (!stat_i.out_stall) begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fgt_q   <= 1'b0;
      cmd_q   <= '{op: DP_NOP, tbl: TBL_CALLER};
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_of(state_d);
      if (in_acc_i) begin
        fgt_q <= (item_cmd_e'(in_cmd_i) == ITEM_SUCCESS);
      end
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o      = cmd_q;
endmodule
`default_nettype wire
